### hw/rtl/wvm_pkg.sv
`timescale 1ns / 1ps

package wvm_pkg;

    // Fixed voice arithmetic
    localparam int FRAC_W               = 9;
    localparam int MIN_VOICES           = 14;
    localparam int VOL_EXP_MAX          = 24;
    localparam int STEP_RESET           = 1 << FRAC_W;
    localparam int PAN_LEFT_RESET       = 116;
    localparam int PAN_RIGHT_RESET      = 141;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_VOICES       = 32;
    localparam int DEF_SAMPLE_ADDR_BITS = 20;

    typedef enum logic [1:0] {
        CMD_WRITE_REG    = 2'd0,
        CMD_READ         = 2'd1,
        CMD_WRITE_SAMPLE = 2'd2,
        CMD_TICK         = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        WR_FREQ       = 4'd0,
        WR_CUR_VOL    = 4'd1,
        WR_START_VOL  = 4'd2,
        WR_END_VOL    = 4'd3,
        WR_RATE       = 4'd4,
        WR_PAN        = 4'd5,
        WR_ADDR       = 4'd6,
        WR_LOOP_START = 4'd7,
        WR_END_ADDR   = 4'd8,
        WR_VOL_CTL    = 4'd9,
        WR_VOICE_CTL  = 4'd10
    } wr_sel_t;

    typedef enum logic [3:0] {
        RD_VOICE_CTL = 4'd0,
        RD_ADDR      = 4'd1,
        RD_RUNNING   = 4'd2
    } rd_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REG_RD,
        ST_REG_MOD,
        ST_CNT_RD,
        ST_CNT_ACC,
        ST_V_RD,
        ST_V_EVAL,
        ST_V_MOD,
        ST_V_S1,
        ST_V_S2,
        ST_V_S3,
        ST_V_INT,
        ST_V_PL,
        ST_V_PR,
        ST_V_ACR,
        ST_V_WB,
        ST_FIN
    } state_t;

    // Logarithmic pan attenuation per side
    function automatic logic [11:0] pan_lookup(input logic [3:0] b);
        logic [11:0] v;
        case (b)
            4'd0:    v = 12'd0;
            4'd1:    v = 12'd13;
            4'd2:    v = 12'd26;
            4'd3:    v = 12'd41;
            4'd4:    v = 12'd57;
            4'd5:    v = 12'd75;
            4'd6:    v = 12'd94;
            4'd7:    v = 12'd116;
            4'd8:    v = 12'd141;
            4'd9:    v = 12'd169;
            4'd10:   v = 12'd203;
            4'd11:   v = 12'd244;
            4'd12:   v = 12'd297;
            4'd13:   v = 12'd372;
            4'd14:   v = 12'd500;
            default: v = 12'd4095;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/wvm_voice_ram.sv
`timescale 1ns / 1ps

module wvm_voice_ram import wvm_pkg::*; #(
    parameter int           W     = 8,
    parameter int           DEPTH = DEF_MAX_VOICES,
    parameter logic [W-1:0] INIT  = '0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata
);

    logic [W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     rdata_reg;

    // Mark written entries; unwritten ones read as the reset word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : INIT;
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/wvm_sample_ram.sv
`timescale 1ns / 1ps

module wvm_sample_ram import wvm_pkg::*; #(
    parameter int AW = DEF_SAMPLE_ADDR_BITS
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [2**AW];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/wvm_mod_unit.sv
`timescale 1ns / 1ps

module wvm_mod_unit import wvm_pkg::*; #(
    parameter int AW = DEF_SAMPLE_ADDR_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW-1:0] dividend,
    input  logic [AW-1:0] divisor,
    output logic          done,
    output logic [AW-1:0] remainder
);

    localparam int CW = $clog2(AW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] rem_reg;
    logic [AW-1:0] rem_next;
    logic [AW-1:0] dvd_reg;
    logic [AW-1:0] dvs_reg;
    logic [AW:0]   trial;

    // One restoring step per cycle, dividend bits from the top
    always_comb begin
        trial = {rem_reg, dvd_reg[AW-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = AW'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = trial[AW-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(AW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and remainder registers
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[AW-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/wavetable_voice_mixer.sv
`timescale 1ns / 1ps

// Multi-voice wavetable mixer over a signed 8-bit sample memory. Items on
// the slave stream write a voice register, read voice state, load a sample
// byte or run a tick that mixes all active voices into one saturated stereo
// sample; reads and ticks each give one result on the master stream. Voice
// state lives in one voice memory and is read, updated and written back by a
// sequencer, one voice at a time. In a tick the two sample reads of a playing
// voice share one memory port and one multiplier serves both pans; a voice
// that wraps into its loop passes through the bit-serial modulo unit. A
// result waiting on the master stream holds the sequencer until it is taken.
module wavetable_voice_mixer import wvm_pkg::*; #(
    parameter int MAX_VOICES       = DEF_MAX_VOICES,
    parameter int SAMPLE_ADDR_BITS = DEF_SAMPLE_ADDR_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,   // active_voices
    input  logic        s_tvalid,
    output logic        s_tready,
    // voice_index[4:0], reg_select[8:5], write_value[28:9],
    // mem_address[48:29], sample_byte[56:49]
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,       // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // mix_left[15:0], mix_right[31:16], read_data[51:32]
    output logic [55:0] m_tdata,
    output logic [0:0]  m_tuser        // result_kind[0]
);

    localparam int AW   = SAMPLE_ADDR_BITS;
    localparam int VI_W = $clog2(MAX_VOICES);
    localparam int VW   = 3 * AW + FRAC_W + 3 + 8 + 8 + 12 + 12 + 16 * 5;
    localparam logic [5:0] MAXV = 6'(MAX_VOICES);
    localparam logic [5:0] MINV = 6'(MIN_VOICES);
    localparam logic [VW-1:0] VOICE_INIT = {
        {AW{1'b0}}, {FRAC_W{1'b0}}, {AW{1'b0}}, {AW{1'b0}}, 3'b000,
        8'd1, 8'd1, 12'(PAN_LEFT_RESET), 12'(PAN_RIGHT_RESET),
        16'd0, 16'd0, 16'd0, 16'd0, 16'(STEP_RESET)
    };

    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Input fields
    cmd_t        in_cmd;
    logic [4:0]  in_vi;
    logic [3:0]  in_sel;
    logic [19:0] in_wv;
    logic [19:0] in_ma;
    logic [7:0]  in_sb;
    logic        s_accept;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_vi    = s_tdata[4:0];
    assign in_sel   = s_tdata[8:5];
    assign in_wv    = s_tdata[28:9];
    assign in_ma    = s_tdata[48:29];
    assign in_sb    = s_tdata[56:49];
    assign s_accept = s_tvalid && s_tready;

    // Control and working registers
    state_t              state_reg, state_next;
    logic [5:0]          av_reg;
    logic [5:0]          vcnt_reg;
    logic [5:0]          cnt_reg;
    cmd_t                cmd_reg;
    logic [3:0]          sel_reg;
    logic [19:0]         wv_reg;
    logic [VI_W-1:0]     vi_reg;
    logic [19:0]         rd_reg;
    logic [AW-1:0]       sa_reg;
    logic [AW-1:0]       cur_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [7:0]          vf_reg;
    logic [7:0]          rf_reg;
    logic [7:0]          s1_reg;
    logic [7:0]          s2_reg;
    logic signed [16:0]  smp_reg;
    logic signed [26:0]  prod_reg;
    logic [4:0]          sh_reg;
    logic signed [31:0]  acc_l_reg;
    logic signed [31:0]  acc_r_reg;
    logic                m_tvalid_reg;
    logic [15:0]         ml_reg;
    logic [15:0]         mr_reg;
    logic [19:0]         md_reg;
    logic                mk_reg;

    // Memory and unit ports
    logic                vr_re, vr_we;
    logic [VI_W-1:0]     vr_raddr, vr_waddr;
    logic [VW-1:0]       vr_rdata, vr_wdata;
    logic                sr_we, sr_re;
    logic [AW-1:0]       sr_raddr;
    logic [7:0]          sr_rdata;
    logic                mod_start, mod_done;
    logic [AW-1:0]       mod_rem;

    // Unpacked voice entry
    logic [AW-1:0]       r_cur, r_loop, r_end;
    logic [FRAC_W-1:0]   r_frac;
    logic [2:0]          r_valid;
    logic [7:0]          r_vf, r_rf;
    logic [11:0]         r_panl, r_panr;
    logic [15:0]         r_rate, r_vol, r_startl, r_endl, r_step;

    assign {r_cur, r_frac, r_loop, r_end, r_valid, r_vf, r_rf, r_panl, r_panr,
            r_rate, r_vol, r_startl, r_endl, r_step} = vr_rdata;

    // Voice-index clamp and last-voice test
    logic [5:0] av_m1;
    logic [4:0] vi_cl;
    logic       last_voice;

    assign av_m1      = av_reg - 6'd1;
    assign vi_cl      = ({1'b0, in_vi} > av_m1) ? av_m1[4:0] : in_vi;
    assign last_voice = (vcnt_reg + 6'd1) == av_reg;

    // Evaluate stop bits and end of sample
    logic [7:0]    vf_e, rf_e;
    logic          go_e, at_end_e, loop_ok_e, need_mod_e, play_e;
    logic [AW-1:0] len_e, over_e;

    always_comb begin
        vf_e       = r_vf | {7'b0, r_vf[1]};
        rf_e       = r_rf | {7'b0, r_rf[1]};
        go_e       = !vf_e[0] && r_valid[0] && r_valid[2];
        at_end_e   = r_cur >= r_end;
        loop_ok_e  = vf_e[3] && r_valid[1];
        len_e      = r_end - r_loop;
        over_e     = r_cur - r_end;
        need_mod_e = go_e && at_end_e && loop_ok_e && (len_e != '0);
        play_e     = go_e && !(at_end_e && !loop_ok_e);
    end

    // Interpolation product
    logic signed [8:0]  diff;
    logic signed [18:0] iprod;
    logic signed [18:0] smp_wide;

    always_comb begin
        diff     = $signed({s2_reg[7], s2_reg}) - $signed({s1_reg[7], s1_reg});
        iprod    = diff * $signed({1'b0, r_frac});
        smp_wide = $signed({{3{s1_reg[7]}}, s1_reg, 8'b0}) + (iprod >>> 1);
    end

    // Side gain: exponent and mantissa from volume less pan offset
    logic [11:0]        side_off;
    logic [12:0]        vol13, vl;
    logic [4:0]         vexp;
    logic [4:0]         sh_side;
    logic signed [26:0] sprod;

    always_comb begin
        side_off = (state_reg == ST_V_PL) ? r_panl : r_panr;
        vol13    = r_vol[15:3];
        vl       = (vol13 >= {1'b0, side_off}) ? vol13 - {1'b0, side_off} : 13'd0;
        vexp     = vl[12:8];
        sh_side  = (vexp > 5'(VOL_EXP_MAX)) ? 5'd0 : 5'(VOL_EXP_MAX) - vexp;
        sprod    = smp_reg * $signed({2'b01, vl[7:0]});
    end

    // Address advance
    logic [16:0] fsum;

    assign fsum = {8'b0, r_frac} + {1'b0, r_step};

    // Volume ramp
    logic [15:0] vol_ramp;
    logic [7:0]  rf_ramp;

    always_comb begin
        vol_ramp = r_vol;
        rf_ramp  = rf_reg;
        if (!rf_reg[0]) begin
            if (rf_reg[6]) begin
                vol_ramp = r_vol - r_rate;
                if ($signed(vol_ramp) <= $signed(r_startl)) begin
                    vol_ramp   = r_startl;
                    rf_ramp[0] = 1'b1;
                end
            end else begin
                vol_ramp = r_vol + r_rate;
                if (vol_ramp >= r_endl) begin
                    vol_ramp   = r_endl;
                    rf_ramp[0] = 1'b1;
                end
            end
        end
    end

    // Register write: modify the addressed field
    logic [VW-1:0] reg_word;
    logic [15:0]   rate_enc;

    always_comb begin
        logic [AW-1:0]     n_cur, n_loop, n_end;
        logic [FRAC_W-1:0] n_frac;
        logic [2:0]        n_valid;
        logic [7:0]        n_vf, n_rf;
        logic [11:0]       n_panl, n_panr;
        logic [15:0]       n_rate, n_vol, n_startl, n_endl, n_step;
        n_cur = r_cur; n_frac = r_frac; n_loop = r_loop; n_end = r_end;
        n_valid = r_valid; n_vf = r_vf; n_rf = r_rf; n_panl = r_panl;
        n_panr = r_panr; n_rate = r_rate; n_vol = r_vol; n_startl = r_startl;
        n_endl = r_endl; n_step = r_step;
        rate_enc = {10'b0, wv_reg[5:0]} << (2'd3 - wv_reg[7:6]);
        case (wr_sel_t'(sel_reg))
            WR_FREQ:       n_step = {1'b0, wv_reg[15:1]};
            WR_CUR_VOL:    n_vol = {1'b0, wv_reg[15:1]};
            WR_START_VOL:  n_startl = {1'b0, wv_reg[7:0], 7'b0};
            WR_END_VOL:    n_endl = {1'b0, wv_reg[7:0], 7'b0};
            WR_RATE:       n_rate = rate_enc;
            WR_PAN: begin
                n_panl = pan_lookup(wv_reg[3:0]);
                n_panr = pan_lookup(~wv_reg[3:0]);
            end
            WR_ADDR: begin
                n_cur      = AW'(wv_reg);
                n_frac     = '0;
                n_valid[0] = 1'b1;
            end
            WR_LOOP_START: begin
                n_loop     = AW'(wv_reg);
                n_valid[1] = 1'b1;
            end
            WR_END_ADDR: begin
                n_end      = AW'(wv_reg);
                n_valid[2] = 1'b1;
            end
            WR_VOL_CTL:    n_rf = wv_reg[7:0];
            WR_VOICE_CTL:  n_vf = wv_reg[7:0];
            default: ;
        endcase
        reg_word = {n_cur, n_frac, n_loop, n_end, n_valid, n_vf, n_rf, n_panl, n_panr,
                    n_rate, n_vol, n_startl, n_endl, n_step};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_cmd)
                        CMD_WRITE_REG: state_next = ST_REG_RD;
                        CMD_READ: begin
                            if (rd_sel_t'(in_sel) == RD_RUNNING) begin
                                state_next = ST_CNT_RD;
                            end else begin
                                state_next = ST_REG_RD;
                            end
                        end
                        CMD_TICK: state_next = ST_V_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_REG_RD:  state_next = ST_REG_MOD;
            ST_REG_MOD: state_next = (cmd_reg == CMD_READ) ? ST_FIN : ST_IDLE;
            ST_CNT_RD:  state_next = ST_CNT_ACC;
            ST_CNT_ACC: state_next = last_voice ? ST_FIN : ST_CNT_RD;
            ST_V_RD:    state_next = ST_V_EVAL;
            ST_V_EVAL: begin
                if (need_mod_e) begin
                    state_next = ST_V_MOD;
                end else if (play_e) begin
                    state_next = ST_V_S1;
                end else begin
                    state_next = ST_V_WB;
                end
            end
            ST_V_MOD:   state_next = mod_done ? ST_V_S1 : ST_V_MOD;
            ST_V_S1:    state_next = ST_V_S2;
            ST_V_S2:    state_next = ST_V_S3;
            ST_V_S3:    state_next = ST_V_INT;
            ST_V_INT:   state_next = ST_V_PL;
            ST_V_PL:    state_next = ST_V_PR;
            ST_V_PR:    state_next = ST_V_ACR;
            ST_V_ACR:   state_next = ST_V_WB;
            ST_V_WB:    state_next = last_voice ? ST_FIN : ST_V_RD;
            ST_FIN:     state_next = (!m_tvalid_reg || m_tready) ? ST_IDLE : ST_FIN;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory and unit controls
    always_comb begin
        s_tready  = 1'b0;
        vr_re     = 1'b0;
        vr_raddr  = vcnt_reg[VI_W-1:0];
        vr_we     = 1'b0;
        vr_waddr  = vcnt_reg[VI_W-1:0];
        vr_wdata  = {cur_reg, frac_reg, r_loop, r_end, r_valid, vf_reg, rf_ramp,
                     r_panl, r_panr, r_rate, vol_ramp, r_startl, r_endl, r_step};
        sr_we     = 1'b0;
        sr_re     = 1'b0;
        sr_raddr  = sa_reg;
        mod_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                sr_we    = s_tvalid && (in_cmd == CMD_WRITE_SAMPLE);
            end
            ST_REG_RD: begin
                vr_re    = 1'b1;
                vr_raddr = vi_reg;
            end
            ST_REG_MOD: begin
                vr_we    = (cmd_reg == CMD_WRITE_REG);
                vr_waddr = vi_reg;
                vr_wdata = reg_word;
            end
            ST_CNT_RD, ST_V_RD: vr_re = 1'b1;
            ST_V_EVAL: mod_start = need_mod_e;
            ST_V_S1:   sr_re = 1'b1;
            ST_V_S2: begin
                sr_re    = 1'b1;
                sr_raddr = sa_reg + 1'b1;
            end
            ST_V_WB:   vr_we = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            av_reg       <= MINV;
            vcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_wr_data < MINV) begin
                    av_reg <= MINV;
                end else if (cfg_wr_data > MAXV) begin
                    av_reg <= MAXV;
                end else begin
                    av_reg <= cfg_wr_data;
                end
            end
            if (s_accept) begin
                vcnt_reg <= '0;
            end else if (state_reg == ST_V_WB || state_reg == ST_CNT_ACC) begin
                vcnt_reg <= vcnt_reg + 6'd1;
            end
            if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_reg   <= in_cmd;
                    sel_reg   <= in_sel;
                    wv_reg    <= in_wv;
                    vi_reg    <= vi_cl[VI_W-1:0];
                    cnt_reg   <= '0;
                    acc_l_reg <= '0;
                    acc_r_reg <= '0;
                end
            end
            ST_REG_MOD: begin
                case (rd_sel_t'(sel_reg))
                    RD_VOICE_CTL: rd_reg <= {12'b0, r_vf};
                    RD_ADDR:      rd_reg <= 20'(r_cur);
                    default:      rd_reg <= '0;
                endcase
            end
            ST_CNT_ACC: begin
                if (!r_vf[0] && (r_vol[15:3] > 13'd256)) begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                rd_reg <= 20'(cnt_reg + 6'(!r_vf[0] && (r_vol[15:3] > 13'd256)));
            end
            ST_V_EVAL: begin
                vf_reg   <= (go_e && at_end_e && !loop_ok_e) ? (vf_e | 8'd1) : vf_e;
                rf_reg   <= rf_e;
                sa_reg   <= (go_e && at_end_e && loop_ok_e) ? r_loop : r_cur;
                cur_reg  <= r_cur;
                frac_reg <= r_frac;
            end
            ST_V_MOD: begin
                if (mod_done) begin
                    sa_reg <= r_loop + mod_rem;
                end
            end
            ST_V_S2:  s1_reg <= sr_rdata;
            ST_V_S3:  s2_reg <= sr_rdata;
            ST_V_INT: smp_reg <= smp_wide[16:0];
            ST_V_PL: begin
                prod_reg <= sprod;
                sh_reg   <= sh_side;
            end
            ST_V_PR: begin
                acc_l_reg <= acc_l_reg + 32'(prod_reg >>> sh_reg);
                prod_reg  <= sprod;
                sh_reg    <= sh_side;
            end
            ST_V_ACR: begin
                acc_r_reg <= acc_r_reg + 32'(prod_reg >>> sh_reg);
                cur_reg   <= sa_reg + AW'(fsum[16:FRAC_W]);
                frac_reg  <= fsum[FRAC_W-1:0];
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    mk_reg <= (cmd_reg == CMD_READ);
                    ml_reg <= (cmd_reg == CMD_TICK) ? sat16(acc_l_reg) : 16'd0;
                    mr_reg <= (cmd_reg == CMD_TICK) ? sat16(acc_r_reg) : 16'd0;
                    md_reg <= (cmd_reg == CMD_READ) ? rd_reg : 20'd0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, md_reg, mr_reg, ml_reg};
    assign m_tuser  = mk_reg;

    wvm_voice_ram #(
        .W     (VW),
        .DEPTH (MAX_VOICES),
        .INIT  (VOICE_INIT)
    ) u_voice_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (vr_re),
        .raddr   (vr_raddr),
        .rdata   (vr_rdata),
        .we      (vr_we),
        .waddr   (vr_waddr),
        .wdata   (vr_wdata)
    );

    wvm_sample_ram #(
        .AW (AW)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (sr_we),
        .waddr (AW'(in_ma)),
        .wdata (in_sb),
        .re    (sr_re),
        .raddr (sr_raddr),
        .rdata (sr_rdata)
    );

    wvm_mod_unit #(
        .AW (AW)
    ) u_mod_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (over_e),
        .divisor   (len_e),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Voice walk never passes the active voice count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (vcnt_reg <= av_reg))
        else $error("voice counter beyond active voices");

    // Active voice count stays within its saturated range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (av_reg >= MINV) && (av_reg <= MAXV))
        else $error("active voice count out of range");

    // Accepted tick starts the voice walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_cmd == CMD_TICK) |=> (state_reg == ST_V_RD))
        else $error("tick did not start voice walk");

    // Modulo result arrives only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_V_MOD))
        else $error("modulo done outside wait state");

endmodule
